[hdl/fut_pkg.sv]
// ----------------------------------------------------------------------------
// Form URL-encoded tokenizer package
// Item types, character codes, escape states and hex digit helpers.
// ----------------------------------------------------------------------------
package fut_pkg;

   localparam int unsigned RSP_DEPTH = 5;
   localparam int unsigned CAND_NUM  = 9;
   localparam int unsigned CNT_W     = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] HEX_SPAN = 8'd5;
   localparam logic [3:0] HEX_TEN  = 4'd10;

   typedef enum logic [2:0] {
      ESC_NONE = 3'b001,
      ESC_PCT  = 3'b010,
      ESC_HEX  = 3'b100
   } esc_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       body_last;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       in_value;
      logic       string_end;
      logic       pair_end;
      logic       body_end;
      logic       run_last;
   } rsp_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_UA && c <= CH_UA + HEX_SPAN) ||
               (c >= CH_LA && c <= CH_LA + HEX_SPAN);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         hex_val = d[3:0];
      end else if (c >= CH_UA && c <= CH_UA + HEX_SPAN) begin
         d = c - CH_UA;
         hex_val = d[3:0] + HEX_TEN;
      end else begin
         d = c - CH_LA;
         hex_val = d[3:0] + HEX_TEN;
      end
   endfunction

   function automatic rsp_type mk_rsp(input logic has, input logic [7:0] b,
                                      input logic inval, input logic send,
                                      input logic pend);
      rsp_type r;
      r.has_byte   = has;
      r.out_byte   = has ? b : 8'd0;
      r.in_value   = inval;
      r.string_end = send;
      r.pair_end   = pend;
      r.body_end   = 1'b0;
      r.run_last   = 1'b0;
      mk_rsp = r;
   endfunction

endpackage

[hdl/form_urlencoded_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// Form URL-encoded tokenizer
// Usage: feed the raw form body one byte per item on req_ (in_byte, with
// body_last on the final byte). Decoded bytes come out on rsp_, tagged key
// or value, with byte-less string end and pair end markers; run_last marks
// the last result of an input byte and body_end the last of the body.
// An accepted item sits in the input register, is decoded in one pass into
// a result list of up to five entries and the entries leave one per cycle
// while rsp_ready is high. The first result of an item is offered once the
// result list, when free, has taken the item from the input register.
// Throughput: one byte per cycle while each gives at most one result and
// rsp_ready is high; a byte with more results holds the list until all have
// left. A first hex digit, or a '%' with no escape pending, gives no result
// unless last. When the receiver stalls, the result list holds and one more
// item waits in the input register; req_ready drops after that.
// Reset (synchronous, active high) empties both stages and returns the
// decoder to key parsing with no pending escape.
// ----------------------------------------------------------------------------
module form_urlencoded_tokenizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fut_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fut_pkg::rsp_type rsp_data
);

   logic                     in_vld_ff, in_vld_in;
   fut_pkg::req_type         in_data_ff;
   fut_pkg::rsp_type         list_ff [fut_pkg::RSP_DEPTH];
   fut_pkg::rsp_type         list_in [fut_pkg::RSP_DEPTH];
   logic [fut_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [fut_pkg::CNT_W-1:0] head_ff, head_in;
   logic                     vm_ff, vm_in;
   fut_pkg::esc_type         esc_ff, esc_in;
   logic [7:0]               efc_ff, efc_in;
   logic                     seg_ff, seg_in;

   logic                     last_pop, list_free, move;
   logic                     hx, plain, is_amp, is_eq, is_pct, is_plus;
   logic                     vm_mid, seg_mid, blast;
   fut_pkg::esc_type         esc_mid;
   logic [7:0]               b, efc_mid, main_byte;
   fut_pkg::rsp_type         cand [fut_pkg::CAND_NUM];
   logic [fut_pkg::CAND_NUM-1:0] cand_en;
   logic [fut_pkg::CNT_W-1:0] n;

   // output side
   assign rsp_valid = head_ff != cnt_ff;
   assign rsp_data  = list_ff[head_ff];
   assign last_pop  = rsp_valid && rsp_ready && (head_ff + 1'b1 == cnt_ff);
   assign list_free = !rsp_valid || last_pop;
   assign move      = in_vld_ff && list_free;
   assign req_ready = !in_vld_ff || move;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !move);

   // decode one item
   always_comb begin
      b       = in_data_ff.in_byte;
      blast   = in_data_ff.body_last;
      hx      = fut_pkg::is_hex(b);
      is_amp  = b == fut_pkg::CH_AMP;
      is_eq   = b == fut_pkg::CH_EQ;
      is_pct  = b == fut_pkg::CH_PCT;
      is_plus = b == fut_pkg::CH_PLUS;
      plain   = (esc_ff == fut_pkg::ESC_NONE) || !hx;

      if (esc_ff == fut_pkg::ESC_HEX && hx) begin
         main_byte = {fut_pkg::hex_val(efc_ff), fut_pkg::hex_val(b)};
      end else if (is_plus) begin
         main_byte = fut_pkg::CH_SPACE;
      end else begin
         main_byte = b;
      end

      vm_mid  = vm_ff;
      seg_mid = seg_ff;
      efc_mid = efc_ff;
      esc_mid = fut_pkg::ESC_NONE;
      if (esc_ff == fut_pkg::ESC_PCT && hx) begin
         efc_mid = b;
         esc_mid = fut_pkg::ESC_HEX;
      end else if (plain) begin
         seg_mid = !is_amp;
         if (is_amp) begin
            vm_mid = 1'b0;
         end else if (is_eq) begin
            vm_mid = 1'b1;
         end
         if (is_pct && !is_amp) begin
            esc_mid = fut_pkg::ESC_PCT;
         end
      end

      cand[0] = fut_pkg::mk_rsp(1'b1, fut_pkg::CH_PCT, vm_ff, 1'b0, 1'b0);
      cand[1] = fut_pkg::mk_rsp(1'b1, efc_ff, vm_ff, 1'b0, 1'b0);
      cand[2] = fut_pkg::mk_rsp(1'b1, main_byte, vm_ff, 1'b0, 1'b0);
      cand[3] = fut_pkg::mk_rsp(1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
      cand[4] = fut_pkg::mk_rsp(1'b0, 8'd0, 1'b1, 1'b1, 1'b1);
      cand[5] = fut_pkg::mk_rsp(1'b1, fut_pkg::CH_PCT, vm_mid, 1'b0, 1'b0);
      cand[6] = fut_pkg::mk_rsp(1'b1, efc_mid, vm_mid, 1'b0, 1'b0);
      cand[7] = fut_pkg::mk_rsp(1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
      cand[8] = fut_pkg::mk_rsp(1'b0, 8'd0, 1'b1, 1'b1, 1'b1);

      cand_en[0] = (esc_ff != fut_pkg::ESC_NONE) && !hx;
      cand_en[1] = (esc_ff == fut_pkg::ESC_HEX) && !hx;
      cand_en[2] = ((esc_ff == fut_pkg::ESC_HEX) && hx) ||
                   (plain && !is_amp && !is_pct && !(is_eq && !vm_ff));
      cand_en[3] = plain && (is_amp || is_eq) && !vm_ff;
      cand_en[4] = plain && is_amp;
      cand_en[5] = blast && (esc_mid != fut_pkg::ESC_NONE);
      cand_en[6] = blast && (esc_mid == fut_pkg::ESC_HEX);
      cand_en[7] = blast && seg_mid && !vm_mid;
      cand_en[8] = blast && seg_mid;

      // pack enabled results in order
      n = '0;
      for (int i = 0; i < fut_pkg::RSP_DEPTH; i++) begin
         list_in[i] = '0;
      end
      for (int i = 0; i < fut_pkg::CAND_NUM; i++) begin
         if (cand_en[i] && n != fut_pkg::CNT_W'(fut_pkg::RSP_DEPTH)) begin
            list_in[n] = cand[i];
            n          = n + 1'b1;
         end
      end
      if (n != '0) begin
         list_in[n - 1'b1].run_last = 1'b1;
         list_in[n - 1'b1].body_end = blast;
      end

      if (blast) begin
         vm_in  = 1'b0;
         esc_in = fut_pkg::ESC_NONE;
         efc_in = 8'd0;
         seg_in = 1'b0;
      end else begin
         vm_in  = vm_mid;
         esc_in = esc_mid;
         efc_in = efc_mid;
         seg_in = seg_mid;
      end

      cnt_in  = cnt_ff;
      head_in = head_ff;
      if (move) begin
         cnt_in  = n;
         head_in = '0;
      end else if (rsp_valid && rsp_ready) begin
         head_in = head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= '0;
         head_ff   <= '0;
         vm_ff     <= 1'b0;
         esc_ff    <= fut_pkg::ESC_NONE;
         efc_ff    <= 8'd0;
         seg_ff    <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         if (move) begin
            vm_ff  <= vm_in;
            esc_ff <= esc_in;
            efc_ff <= efc_in;
            seg_ff <= seg_in;
         end
      end
   end

   // payload: hold unless loading
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         list_ff <= list_in;
      end
   end

`ifndef ASSERT_OFF
   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= cnt_ff)
      else $error("result head beyond result count");

   a_last_entry_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (head_ff + 1'b1 == cnt_ff)) |-> rsp_data.run_last)
      else $error("last result of an item lacks run_last");

   a_body_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.body_end) |-> rsp_data.run_last)
      else $error("body_end on a result that is not the last of its item");

   a_body_reset: assert property (@(posedge clock) disable iff (reset)
      (move && in_data_ff.body_last) |=>
         (esc_ff == fut_pkg::ESC_NONE && !vm_ff && !seg_ff))
      else $error("decoder state not cleared after final byte");
`endif

endmodule
